/* src/clea_pkg.sv */
package clea_pkg;

   localparam int DEF_MAX_CYCLE_SAMPLES = 256;
   localparam int DEF_SAMPLE_BITS       = 16;

   localparam int SMOOTH_W    = 17;
   localparam int CYC_LEN_W   = 9;
   localparam int PHASE_W     = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;

   localparam logic [SMOOTH_W-1:0]  ONE_Q16          = 17'h10000;
   localparam logic [SMOOTH_W-1:0]  SMOOTHING_RESET  = 17'h08000;
   localparam logic [CYC_LEN_W-1:0] CYCLE_LEN_RESET  = 9'd200;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SMOOTHING    = 1'b0,
      CSR_CYCLE_LENGTH = 1'b1
   } csr_index_type;

endpackage

/* src/cycle_locked_exponential_average_unit.sv */
// path: the req transaction passes stage 1, stage 2 and the output register to rsp_tvalid
// throughput: one sample per cycle; the line store is read at accept and
// written as the sample leaves stage 2, same-phase overlaps are served by forwarding;
// a held rsp transaction stalls every stage and req_tready together
// reset: synchronous, active high; clears the phase counter and pipeline valids,
// sets the first-cycle flag, loads default smoothing and cycle length; no clearing pass
module cycle_locked_exponential_average_unit
   import clea_pkg::*;
#(
   parameter int MAX_CYCLE_SAMPLES = DEF_MAX_CYCLE_SAMPLES,
   parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS,
   localparam int REQ_W = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((SAMPLE_BITS + PHASE_W + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample
   input  logic [REQ_W-1:0]       req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // modeled, phase
   output logic [RSP_W-1:0]       rsp_tdata,
   output logic                   rsp_tlast,
   // first_pass
   output logic                   rsp_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W  = $clog2(MAX_CYCLE_SAMPLES);
   localparam int LEN_W  = (IDX_W + 1 > CYC_LEN_W) ? IDX_W + 1 : CYC_LEN_W;
   localparam int PROD_W = SAMPLE_BITS + SMOOTH_W;

   // configuration
   logic [SMOOTH_W-1:0]  smoothing_ff, smoothing_in;
   logic [CYC_LEN_W-1:0] cycle_len_ff, cycle_len_in;

   // phase tracking
   logic [IDX_W-1:0] phase_ff, phase_in;
   logic             first_ff, first_in;

   // line store
   logic [SAMPLE_BITS-1:0] line_mem [MAX_CYCLE_SAMPLES];
   logic [SAMPLE_BITS-1:0] rd_ff;

   // stage 1
   logic                   s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0]       s1_ph_ff;
   logic [SAMPLE_BITS-1:0] s1_smp_ff;
   logic                   s1_last_ff;
   logic                   s1_first_ff;

   // stage 2
   logic                   s2_vld_ff, s2_vld_in;
   logic [IDX_W-1:0]       s2_ph_ff;
   logic [SAMPLE_BITS-1:0] s2_smp_ff;
   logic [PROD_W-1:0]      s2_prod_ff, s2_prod_in;
   logic [SAMPLE_BITS-1:0] s2_prev_ff, s2_prev_in;
   logic                   s2_last_ff;
   logic                   s2_first_ff;

   // last write, for forwarding
   logic                   wr_vld_ff, wr_vld_in;
   logic [IDX_W-1:0]       wr_ph_ff;
   logic [SAMPLE_BITS-1:0] wr_data_ff;

   // output register
   logic                   out_vld_ff, out_vld_in;
   logic [SAMPLE_BITS-1:0] out_mod_ff;
   logic [IDX_W-1:0]       out_ph_ff;
   logic                   out_last_ff;
   logic                   out_first_ff;

   logic                   advance;
   logic                   accept;
   logic [SAMPLE_BITS-1:0] sample;
   logic [LEN_W-1:0]       len_eff;
   logic                   last_cur;
   logic [SMOOTH_W-1:0]    alpha;
   logic [SMOOTH_W-1:0]    beta;
   logic [SAMPLE_BITS-1:0] smp_off;
   logic [SAMPLE_BITS-1:0] prev_sel;
   logic [SAMPLE_BITS-1:0] prev_off;
   logic [PROD_W-1:0]      sum;
   logic [SAMPLE_BITS-1:0] quot;
   logic [SAMPLE_BITS-1:0] result;

   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign sample     = req_tdata[SAMPLE_BITS-1:0];
   assign csr_ready  = 1'b1;

   // configuration writes
   always_comb begin
      smoothing_in = smoothing_ff;
      cycle_len_in = cycle_len_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SMOOTHING:    smoothing_in = csr_data[SMOOTH_W-1:0];
            CSR_CYCLE_LENGTH: cycle_len_in = csr_data[CYC_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // effective cycle length and end of cycle
   always_comb begin
      len_eff = LEN_W'(cycle_len_ff);
      if (len_eff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_eff > LEN_W'(MAX_CYCLE_SAMPLES)) begin
         len_eff = LEN_W'(MAX_CYCLE_SAMPLES);
      end
      last_cur = (LEN_W'(phase_ff) + LEN_W'(1)) >= len_eff;
      phase_in = phase_ff;
      first_in = first_ff;
      if (accept) begin
         if (last_cur) begin
            phase_in = '0;
            first_in = 1'b0;
         end else begin
            phase_in = phase_ff + IDX_W'(1);
         end
      end
   end

   // stage 1: sample product and forwarding of a write at the read edge
   always_comb begin
      alpha      = (smoothing_ff > ONE_Q16) ? ONE_Q16 : smoothing_ff;
      smp_off    = {~s1_smp_ff[SAMPLE_BITS-1], s1_smp_ff[SAMPLE_BITS-2:0]};
      s2_prod_in = PROD_W'(alpha) * PROD_W'(smp_off);
      s2_prev_in = (wr_vld_ff && wr_ph_ff == s1_ph_ff) ? wr_data_ff : rd_ff;
   end

   // stage 2: history product, sum and truncating shift, or the raw sample on the first pass
   always_comb begin
      beta     = ONE_Q16 - alpha;
      prev_sel = (wr_vld_ff && wr_ph_ff == s2_ph_ff) ? wr_data_ff : s2_prev_ff;
      prev_off = {~prev_sel[SAMPLE_BITS-1], prev_sel[SAMPLE_BITS-2:0]};
      sum      = s2_prod_ff + PROD_W'(beta) * PROD_W'(prev_off);
      quot     = sum[SAMPLE_BITS+15:16];
      result   = s2_first_ff ? s2_smp_ff : {~quot[SAMPLE_BITS-1], quot[SAMPLE_BITS-2:0]};
   end

   always_comb begin
      s1_vld_in  = advance ? accept : s1_vld_ff;
      s2_vld_in  = advance ? s1_vld_ff : s2_vld_ff;
      out_vld_in = advance ? s2_vld_ff : out_vld_ff;
      wr_vld_in  = wr_vld_ff || (advance && s2_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothing_ff <= SMOOTHING_RESET;
         cycle_len_ff <= CYCLE_LEN_RESET;
         phase_ff     <= '0;
         first_ff     <= 1'b1;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         wr_vld_ff    <= 1'b0;
      end else begin
         smoothing_ff <= smoothing_in;
         cycle_len_ff <= cycle_len_in;
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         out_vld_ff   <= out_vld_in;
         wr_vld_ff    <= wr_vld_in;
      end
   end

   // line store read
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[phase_ff];
      end
   end

   // line store write
   always_ff @(posedge clock) begin
      if (advance && s2_vld_ff) begin
         line_mem[s2_ph_ff] <= result;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ph_ff    <= phase_ff;
         s1_smp_ff   <= sample;
         s1_last_ff  <= last_cur;
         s1_first_ff <= first_ff;
      end
      if (advance) begin
         s2_ph_ff    <= s1_ph_ff;
         s2_smp_ff   <= s1_smp_ff;
         s2_prod_ff  <= s2_prod_in;
         s2_prev_ff  <= s2_prev_in;
         s2_last_ff  <= s1_last_ff;
         s2_first_ff <= s1_first_ff;
      end
      if (advance && s2_vld_ff) begin
         wr_ph_ff     <= s2_ph_ff;
         wr_data_ff   <= result;
         out_mod_ff   <= result;
         out_ph_ff    <= s2_ph_ff;
         out_last_ff  <= s2_last_ff;
         out_first_ff <= s2_first_ff;
      end
   end

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[SAMPLE_BITS-1:0] = out_mod_ff;
      rsp_tdata[SAMPLE_BITS+PHASE_W-1:SAMPLE_BITS] = PHASE_W'(out_ph_ff);
   end

   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_first_ff;
   assign rsp_tvalid = out_vld_ff;

endmodule
